/* rtl/wspc_pkg.sv */
package wspc_pkg;

	// Character storage and field widths.
	localparam int REG_CHARS       = 16;
	localparam int PATTERN_MAX_DEF = 16;
	localparam int CHAR_W          = 8;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_INDEX_W     = 2;
	localparam int LEN_W           = 5;
	localparam int CNT_W           = 8;
	localparam int ROW_W           = 20;
	localparam int COL_W           = 16;
	localparam int TOTAL_W         = 32;

	localparam logic [ROW_W-1:0] ROW_MAX = '1;
	localparam logic [COL_W-1:0] COL_MAX = '1;

	localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PATTERN_LOW    = 2'd0,
		CFG_PATTERN_HIGH   = 2'd1,
		CFG_PATTERN_LENGTH = 2'd2
	} cfg_index_t;

	typedef logic [REG_CHARS-1:0][CHAR_W-1:0] pattern_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} pos_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} hit_t;

	typedef struct packed {
		logic [CNT_W-1:0]   matches_here;
		logic [ROW_W-1:0]   start_row;
		logic [COL_W-1:0]   start_column;
		logic [TOTAL_W-1:0] total_matches;
		logic               text_done;
	} result_t;

	// Number of pattern characters the design can hold.
	function automatic int cell_count(int pattern_max);
		return (pattern_max < REG_CHARS) ? pattern_max : REG_CHARS;
	endfunction

endpackage

/* rtl/wspc_cfg_regs.sv */
module wspc_cfg_regs
	import wspc_pkg::*;
#(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data,
	output pattern_t               pattern,
	output logic [LEN_W-1:0]       length
);

	localparam int CELLS = cell_count(PATTERN_MAX);

	pattern_t         pattern_q;
	logic [LEN_W-1:0] length_q;
	logic [LEN_W-1:0] wr_len;

	// The length is stored already clamped to the range the cells support.
	always_comb begin
		wr_len = wr_data[LEN_W-1:0];
		if (wr_len == '0) begin
			wr_len = LEN_W'(1);
		end else if (wr_len > LEN_W'(CELLS)) begin
			wr_len = LEN_W'(CELLS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			length_q  <= LEN_W'(1);
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_PATTERN_LOW:    pattern_q[7:0]  <= wr_data;
				CFG_PATTERN_HIGH:   pattern_q[15:8] <= wr_data;
				CFG_PATTERN_LENGTH: length_q        <= wr_len;
				default: ;
			endcase
		end
	end

	assign pattern = pattern_q;
	assign length  = length_q;

endmodule

/* rtl/wspc_cells.sv */
module wspc_cells
	import wspc_pkg::*;
#(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [CHAR_W-1:0] text_byte,
	input  logic              is_space,
	input  logic              end_of_text,
	input  pattern_t          pattern,
	input  logic [LEN_W-1:0]  length,
	input  pos_t              pos,
	output hit_t              hit
);

	localparam int CELLS = cell_count(PATTERN_MAX);

	logic [CELLS-1:0] active_q;
	logic [CNT_W-1:0] cnt_q [CELLS];
	logic [ROW_W-1:0] row_q [CELLS];
	logic [COL_W-1:0] col_q [CELLS];

	logic [CELLS-1:0] in_use;
	logic [CELLS-1:0] char_eq;
	logic [CELLS-1:0] live;
	logic [CELLS-1:0] nxt_active;
	logic [CNT_W-1:0] nxt_cnt [CELLS];
	logic [ROW_W-1:0] nxt_row [CELLS];
	logic [COL_W-1:0] nxt_col [CELLS];

	logic             new_start;
	logic [CNT_W:0]   merge_sum;
	logic [CNT_W-1:0] merge_cnt;
	logic             start_earlier;

	// Cell k holds prefixes of k+1 characters; only cells below length-1 count.
	always_comb begin
		for (int k = 0; k < CELLS; k++) begin
			in_use[k]  = (k + 1) < int'(length);
			char_eq[k] = text_byte == pattern[k];
			live[k]    = active_q[k] && in_use[k];
		end
	end

	assign new_start     = char_eq[0] && (length > LEN_W'(1));
	assign merge_sum     = {1'b0, cnt_q[0]} + (CNT_W+1)'(1);
	assign merge_cnt     = merge_sum[CNT_W] ? '1 : merge_sum[CNT_W-1:0];
	assign start_earlier = (pos.row < row_q[0]) ||
		((pos.row == row_q[0]) && (pos.col < col_q[0]));

	always_comb begin
		nxt_active = '0;
		for (int k = 0; k < CELLS; k++) begin
			nxt_cnt[k] = cnt_q[k];
			nxt_row[k] = row_q[k];
			nxt_col[k] = col_q[k];
		end

		// Cell 0 can both hold over a whitespace byte and take a new start.
		priority if (is_space && live[0] && new_start) begin
			nxt_active[0] = 1'b1;
			nxt_cnt[0]    = merge_cnt;
			if (start_earlier) begin
				nxt_row[0] = pos.row;
				nxt_col[0] = pos.col;
			end
		end else if (is_space && live[0]) begin
			nxt_active[0] = 1'b1;
		end else if (new_start) begin
			nxt_active[0] = 1'b1;
			nxt_cnt[0]    = CNT_W'(1);
			nxt_row[0]    = pos.row;
			nxt_col[0]    = pos.col;
		end

		for (int k = 1; k < CELLS; k++) begin
			if (is_space) begin
				nxt_active[k] = live[k];
			end else begin
				nxt_active[k] = live[k-1] && char_eq[k] && in_use[k];
				nxt_cnt[k]    = cnt_q[k-1];
				nxt_row[k]    = row_q[k-1];
				nxt_col[k]    = col_q[k-1];
			end
		end
	end

	// At most one source completes the pattern at a given byte.
	always_comb begin
		hit = '0;
		if ((length == LEN_W'(1)) && char_eq[0]) begin
			hit.count = CNT_W'(1);
			hit.row   = pos.row;
			hit.col   = pos.col;
		end
		for (int j = 0; j < CELLS - 1; j++) begin
			if (!is_space && live[j] && char_eq[j+1] && ((j + 2) == int'(length))) begin
				hit.count = cnt_q[j];
				hit.row   = row_q[j];
				hit.col   = col_q[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (step) begin
			active_q <= end_of_text ? '0 : nxt_active;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			for (int k = 0; k < CELLS; k++) begin
				cnt_q[k] <= nxt_cnt[k];
				row_q[k] <= nxt_row[k];
				col_q[k] <= nxt_col[k];
			end
		end
	end

endmodule

/* rtl/wspc_tracker.sv */
module wspc_tracker
	import wspc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [CHAR_W-1:0]  text_byte,
	input  logic               end_of_text,
	input  logic [CNT_W-1:0]   hits,
	output pos_t               pos,
	output logic [TOTAL_W-1:0] total_next
);

	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W:0]   total_sum;

	assign pos.row    = row_q;
	assign pos.col    = col_q;
	assign total_sum  = {1'b0, total_q} + (TOTAL_W+1)'(hits);
	assign total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= ROW_W'(1);
			col_q   <= COL_W'(1);
			total_q <= '0;
		end else if (step) begin
			if (end_of_text) begin
				row_q   <= ROW_W'(1);
				col_q   <= COL_W'(1);
				total_q <= '0;
			end else begin
				total_q <= total_next;
				if (text_byte == CHAR_NEWLINE) begin
					if (row_q != ROW_MAX) begin
						row_q <= row_q + ROW_W'(1);
					end
					col_q <= COL_W'(1);
				end else if (col_q != COL_MAX) begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

endmodule

/* rtl/wspc_out_skid.sv */
module wspc_out_skid
	import wspc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    main_free;

	assign main_free = !main_valid_q || !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else begin
			skid_valid_q <= skid_valid_q || push;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

/* rtl/whitespace_skipping_pattern_counter.sv */
// Counts occurrences of a configured pattern of 1 to 16 characters in a
// byte stream, skipping spaces, tabs and newlines that fall between pattern
// characters. The input channel takes one text byte per word together with
// an end_of_text flag; the output channel returns exactly one result word
// per input word: the number of matches completing at that byte, the row and
// column of the earliest such match's first character, the running total and
// an echo of end_of_text.
// The configuration channel writes the pattern (two 64-bit words) and its
// length; cfg_ready is always high, and a write takes effect on the next
// input byte. Write configuration only while the block is idle.
// The block takes a new byte every cycle while in_stall is low: all match
// cells update in parallel from the input byte, and the result is registered
// in a two-word output buffer.
// When the receiver stalls, the buffer holds the waiting result and can take
// one more; in_stall rises only once both words are full.
// Reset clears all match cells, sets row and column to 1, clears the total
// and sets the pattern to all zero with length 1. After a byte marked
// end_of_text the same text state is restored; configuration is kept.
module whitespace_skipping_pattern_counter
	import wspc_pkg::*;
#(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,

	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [CHAR_W-1:0]      text_byte,
	input  logic                   end_of_text,

	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [CNT_W-1:0]       matches_here,
	output logic [ROW_W-1:0]       start_row,
	output logic [COL_W-1:0]       start_column,
	output logic [TOTAL_W-1:0]     total_matches,
	output logic                   text_done
);

	pattern_t           pattern;
	logic [LEN_W-1:0]   length;
	logic               step;
	logic               is_space;
	pos_t               pos;
	hit_t               hit;
	logic [TOTAL_W-1:0] total_next;
	result_t            result;
	result_t            out_word;

	assign cfg_ready = 1'b1;
	assign step      = in_valid && !in_stall;

	// Whitespace is skipped between pattern characters; it can still match
	// the first pattern character.
	assign is_space = (text_byte == CHAR_SPACE) || (text_byte == CHAR_TAB) ||
		(text_byte == CHAR_NEWLINE);

	wspc_cfg_regs #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.pattern  (pattern),
		.length   (length)
	);

	wspc_tracker u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.hits        (hit.count),
		.pos         (pos),
		.total_next  (total_next)
	);

	wspc_cells #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_cells (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.text_byte   (text_byte),
		.is_space    (is_space),
		.end_of_text (end_of_text),
		.pattern     (pattern),
		.length      (length),
		.pos         (pos),
		.hit         (hit)
	);

	// With no match the hit position is zero already.
	always_comb begin
		result.matches_here  = hit.count;
		result.start_row     = hit.row;
		result.start_column  = hit.col;
		result.total_matches = total_next;
		result.text_done     = end_of_text;
	end

	wspc_out_skid u_out_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.push_data (result),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_word)
	);

	assign matches_here  = out_word.matches_here;
	assign start_row     = out_word.start_row;
	assign start_column  = out_word.start_column;
	assign total_matches = out_word.total_matches;
	assign text_done     = out_word.text_done;

endmodule

/* test/tb_whitespace_skipping_pattern_counter.sv */
module tb_whitespace_skipping_pattern_counter;
	import wspc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The directed part is a list of rows. A text row sends one word. A settings
	// row first lets the block drain, then rewrites all three registers.
	typedef enum logic {
		PLAN_TEXT,
		PLAN_SETTINGS
	} plan_kind_t;

	typedef struct packed {
		plan_kind_t            kind;
		logic [CHAR_W-1:0]     text;
		logic                  eot;
		logic                  typed;
		result_t               want;
		logic [CFG_DATA_W-1:0] low;
		logic [CFG_DATA_W-1:0] high;
		logic [LEN_W-1:0]      len;
	} plan_row_t;

	localparam int PLAN_ROWS = 27;
	localparam int RANDOM_WORDS = 830;

	// The rows right after reset run with an all-zero pattern of length one, so
	// every zero byte is a hit on its own. Their results are typed in here.
	// Rows without a typed result are checked against the software copy.
	localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
		'{PLAN_TEXT, 8'h00, 1'b0, 1'b1, '{8'd1, 20'd1, 16'd1, 32'd1, 1'b0}, '0, '0, '0},
		'{PLAN_TEXT, 8'hFF, 1'b0, 1'b1, '{8'd0, 20'd0, 16'd0, 32'd1, 1'b0}, '0, '0, '0},
		'{PLAN_TEXT, 8'h0A, 1'b0, 1'b1, '{8'd0, 20'd0, 16'd0, 32'd1, 1'b0}, '0, '0, '0},
		'{PLAN_TEXT, 8'h00, 1'b0, 1'b1, '{8'd1, 20'd2, 16'd1, 32'd2, 1'b0}, '0, '0, '0},
		'{PLAN_TEXT, 8'h00, 1'b1, 1'b1, '{8'd1, 20'd2, 16'd2, 32'd3, 1'b1}, '0, '0, '0},
		'{PLAN_TEXT, 8'h80, 1'b1, 1'b1, '{8'd0, 20'd0, 16'd0, 32'd0, 1'b1}, '0, '0, '0},
		'{PLAN_TEXT, 8'h00, 1'b0, 1'b1, '{8'd1, 20'd1, 16'd1, 32'd1, 1'b0}, '0, '0, '0},
		// "ab" with blanks of every kind between the two characters, then a
		// restart on a repeated first character. The text is not ended first.
		'{PLAN_SETTINGS, 8'h00, 1'b0, 1'b0, '0, 64'h6261, '1, 5'd2},
		'{PLAN_TEXT, 8'h61, 1'b0, 1'b0, '0, '0, '0, '0},
		'{PLAN_TEXT, 8'h20, 1'b0, 1'b0, '0, '0, '0, '0},
		'{PLAN_TEXT, 8'h09, 1'b0, 1'b0, '0, '0, '0, '0},
		'{PLAN_TEXT, 8'h0A, 1'b0, 1'b0, '0, '0, '0, '0},
		'{PLAN_TEXT, 8'h62, 1'b0, 1'b0, '0, '0, '0, '0},
		'{PLAN_TEXT, 8'h61, 1'b0, 1'b0, '0, '0, '0, '0},
		'{PLAN_TEXT, 8'h61, 1'b0, 1'b0, '0, '0, '0, '0},
		'{PLAN_TEXT, 8'h62, 1'b0, 1'b0, '0, '0, '0, '0},
		// A space as first character: two starts merge into one cell.
		'{PLAN_SETTINGS, 8'h00, 1'b0, 1'b0, '0, 64'h7820, '0, 5'd2},
		'{PLAN_TEXT, 8'h20, 1'b0, 1'b0, '0, '0, '0, '0},
		'{PLAN_TEXT, 8'h20, 1'b0, 1'b0, '0, '0, '0, '0},
		'{PLAN_TEXT, 8'h09, 1'b0, 1'b0, '0, '0, '0, '0},
		'{PLAN_TEXT, 8'h78, 1'b0, 1'b0, '0, '0, '0, '0},
		// A length of zero behaves as one.
		'{PLAN_SETTINGS, 8'h00, 1'b0, 1'b0, '0, '1, '0, 5'd0},
		'{PLAN_TEXT, 8'hFF, 1'b1, 1'b0, '0, '0, '0, '0},
		// A tab inside the pattern can never be matched.
		'{PLAN_SETTINGS, 8'h00, 1'b0, 1'b0, '0, 64'h620961, '0, 5'd3},
		'{PLAN_TEXT, 8'h61, 1'b0, 1'b0, '0, '0, '0, '0},
		'{PLAN_TEXT, 8'h09, 1'b0, 1'b0, '0, '0, '0, '0},
		'{PLAN_TEXT, 8'h62, 1'b1, 1'b0, '0, '0, '0, '0}
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [CHAR_W-1:0]      text_byte = '0;
	logic                   end_of_text = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [CNT_W-1:0]       matches_here;
	logic [ROW_W-1:0]       start_row;
	logic [COL_W-1:0]       start_column;
	logic [TOTAL_W-1:0]     total_matches;
	logic                   text_done;

	// Both sides insert random gaps only while this is set.
	bit idling = 1'b1;

	// A typed result for the word on the input, if the current row has one.
	logic    plan_typed = 1'b0;
	result_t plan_want = '0;

	result_t due_reports [$];
	int      mismatches = 0;
	int      random_sent = 0;

	// Copy of the registers as they were written to the block.
	logic [CFG_DATA_W-1:0] chars_low;
	logic [CFG_DATA_W-1:0] chars_high;
	logic [LEN_W-1:0]      length_reg;

	// Copy of the text state: one cell per matched prefix, and the position.
	logic [REG_CHARS-1:0] live;
	int unsigned          live_count [REG_CHARS];
	int unsigned          live_row [REG_CHARS];
	int unsigned          live_col [REG_CHARS];
	int unsigned          row_now;
	int unsigned          col_now;
	longint unsigned      total_now;

	// The cells as they are built up for the next byte.
	logic [REG_CHARS-1:0] next_live;
	int unsigned          next_count [REG_CHARS];
	int unsigned          next_row [REG_CHARS];
	int unsigned          next_col [REG_CHARS];

	whitespace_skipping_pattern_counter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.text_byte    (text_byte),
		.end_of_text  (end_of_text),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.matches_here (matches_here),
		.start_row    (start_row),
		.start_column (start_column),
		.total_matches(total_matches),
		.text_done    (text_done)
	);

	initial begin
		forever begin
			#10 clk = ~clk;
		end
	end

	// Pattern character j, taken from the two character registers.
	function automatic logic [CHAR_W-1:0] pattern_char(int j);
		if (j < 8) begin
			return chars_low[8*j +: 8];
		end
		return chars_high[8*(j-8) +: 8];
	endfunction

	// The length register clamped to what the block can hold.
	function automatic int used_length();
		int n;
		n = int'(length_reg);
		if (n < 1) begin
			n = 1;
		end
		if (n > cell_count(PATTERN_MAX_DEF)) begin
			n = cell_count(PATTERN_MAX_DEF);
		end
		return n;
	endfunction

	function automatic bit is_blank(logic [CHAR_W-1:0] b);
		return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_NEWLINE;
	endfunction

	// Adds a group of starts to cell j of the next state. If the cell is
	// already taken, the counts add up to at most 255 and the earlier of the
	// two start positions wins.
	function automatic void fold_start(int j, int unsigned c, int unsigned r, int unsigned k);
		if (!next_live[j]) begin
			next_live[j] = 1'b1;
			next_count[j] = c;
			next_row[j] = r;
			next_col[j] = k;
			return;
		end
		next_count[j] = (next_count[j] + c > 255) ? 255 : next_count[j] + c;
		if (r < next_row[j] || (r == next_row[j] && k < next_col[j])) begin
			next_row[j] = r;
			next_col[j] = k;
		end
	endfunction

	function automatic void clear_text();
		live = '0;
		foreach (live_count[j]) begin
			live_count[j] = 0;
			live_row[j] = 0;
			live_col[j] = 0;
		end
		row_now = 1;
		col_now = 1;
		total_now = 0;
	endfunction

	// Works out the result word for one text byte and moves the text state on.
	function automatic result_t scan_byte(logic [CHAR_W-1:0] b, logic eot);
		result_t     r;
		bit          blank;
		int          len;
		int unsigned hits;
		int unsigned hit_row;
		int unsigned hit_col;
		blank = is_blank(b);
		len = used_length();
		hits = 0;
		hit_row = 0;
		hit_col = 0;
		next_live = '0;
		foreach (next_count[j]) begin
			next_count[j] = 0;
			next_row[j] = 0;
			next_col[j] = 0;
		end
		// Cells 0 to len-2 hold partial matches. A blank keeps every one of
		// them where it is; a matching byte moves a cell up or completes it.
		for (int j = 0; j + 1 < len; j++) begin
			if (!live[j]) begin
				continue;
			end
			if (blank) begin
				fold_start(j, live_count[j], live_row[j], live_col[j]);
			end else if (b == pattern_char(j + 1)) begin
				if (j + 2 == len) begin
					hits = live_count[j];
					hit_row = live_row[j];
					hit_col = live_col[j];
				end else begin
					fold_start(j + 1, live_count[j], live_row[j], live_col[j]);
				end
			end
		end
		// A new start at this byte, or a hit right away for a one-byte pattern.
		if (b == pattern_char(0)) begin
			if (len == 1) begin
				hits = 1;
				hit_row = row_now;
				hit_col = col_now;
			end else begin
				fold_start(0, 1, row_now, col_now);
			end
		end
		live = next_live;
		live_count = next_count;
		live_row = next_row;
		live_col = next_col;
		if (b == CHAR_NEWLINE) begin
			if (row_now < ROW_MAX) begin
				row_now++;
			end
			col_now = 1;
		end else if (col_now < COL_MAX) begin
			col_now++;
		end
		total_now = (total_now + hits > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : total_now + hits;
		r.matches_here = CNT_W'(hits);
		r.start_row = (hits == 0) ? '0 : ROW_W'(hit_row);
		r.start_column = (hits == 0) ? '0 : COL_W'(hit_col);
		r.total_matches = TOTAL_W'(total_now);
		r.text_done = eot;
		if (eot) begin
			clear_text();
		end
		return r;
	endfunction

	// Compares one result word from the block with the oldest prediction.
	function automatic void check_report(result_t got);
		result_t want;
		if (due_reports.size() == 0) begin
			$display("%0t: result word with nothing expected: %p", $time, got);
			mismatches++;
			return;
		end
		want = due_reports.pop_front();
		if (got.matches_here !== want.matches_here) begin
			$display("%0t: matches_here expected %0d, got %0d",
				$time, want.matches_here, got.matches_here);
			mismatches++;
		end
		if (got.start_row !== want.start_row) begin
			$display("%0t: start_row expected %0d, got %0d",
				$time, want.start_row, got.start_row);
			mismatches++;
		end
		if (got.start_column !== want.start_column) begin
			$display("%0t: start_column expected %0d, got %0d",
				$time, want.start_column, got.start_column);
			mismatches++;
		end
		if (got.total_matches !== want.total_matches) begin
			$display("%0t: total_matches expected %0d, got %0d",
				$time, want.total_matches, got.total_matches);
			mismatches++;
		end
		if (got.text_done !== want.text_done) begin
			$display("%0t: text_done expected %0b, got %0b",
				$time, want.text_done, got.text_done);
			mismatches++;
		end
	endfunction

	// Everything is sampled at the rising edge; the stimulus only moves at the
	// falling edge, so the order of processes within a step does not matter.
	// Register writes mirror into the copy here, each accepted text word is
	// predicted here, and each accepted result word is checked here.
	always @(posedge clk) begin : watch
		result_t predicted;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index_t'(cfg_index))
					CFG_PATTERN_LOW: begin
						chars_low = cfg_data;
					end
					CFG_PATTERN_HIGH: begin
						chars_high = cfg_data;
					end
					CFG_PATTERN_LENGTH: begin
						length_reg = cfg_data[LEN_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (in_valid && !in_stall) begin
				predicted = scan_byte(text_byte, end_of_text);
				due_reports.push_back(plan_typed ? plan_want : predicted);
			end
			if (out_valid && !out_stall) begin
				check_report('{matches_here, start_row, start_column, total_matches,
					text_done});
			end
		end
	end

	// Receiving side: before each result word it may hold stall high for a
	// random number of cycles, then takes the word as soon as it shows up.
	initial begin : drain
		int hold;
		wait (arst_n);
		@(negedge clk);
		forever begin
			hold = idling ? $urandom_range(0, 12) : 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!out_valid) begin
				@(posedge clk);
			end
			@(negedge clk);
		end
	end

	// Sends one text word. Called at a falling edge and returns at the falling
	// edge after the word was taken, with valid still high so that a word
	// without a gap can follow at once.
	task automatic push_text(logic [CHAR_W-1:0] b, logic eot, logic typed = 1'b0,
		result_t want = '0);
		int gap;
		gap = idling ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		plan_typed = typed;
		plan_want = want;
		in_valid <= 1'b1;
		text_byte <= b;
		end_of_text <= eot;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Random words end the text now and then.
	task automatic push_random(logic [CHAR_W-1:0] b);
		push_text(b, $urandom_range(0, 39) == 0);
		random_sent++;
	endtask

	// Stops sending and waits until every predicted word has come back.
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (due_reports.size() != 0) begin
			@(negedge clk);
		end
		repeat (3) @(negedge clk);
	endtask

	task automatic put_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Writes all three registers. The bits of the length word above the
	// length field are random, since only the low five bits count.
	task automatic write_settings(logic [CFG_DATA_W-1:0] low, logic [CFG_DATA_W-1:0] high,
		logic [LEN_W-1:0] len);
		logic [CFG_DATA_W-1:0] len_word;
		len_word = {$urandom, $urandom};
		len_word[LEN_W-1:0] = len;
		put_register(CFG_PATTERN_LOW, low);
		put_register(CFG_PATTERN_HIGH, high);
		put_register(CFG_PATTERN_LENGTH, len_word);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [CHAR_W-1:0] draw_blank();
		case ($urandom_range(0, 2))
			0: return CHAR_SPACE;
			1: return CHAR_TAB;
			default: return CHAR_NEWLINE;
		endcase
	endfunction

	// Pattern characters come mostly from a three-letter alphabet so that
	// overlapping and repeated starts are common.
	function automatic logic [CHAR_W-1:0] draw_pattern_char();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return CHAR_W'(8'h61 + $urandom_range(0, 2));
			6: return draw_blank();
			default: return CHAR_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Lengths favor short patterns but hit zero, one, sixteen, values above
	// sixteen and the all-ones field.
	function automatic logic [LEN_W-1:0] draw_length();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return LEN_W'(16);
			3: return LEN_W'(1);
			4: return LEN_W'($urandom_range(17, 30));
			default: return LEN_W'($urandom_range(2, 8));
		endcase
	endfunction

	task automatic write_random_settings();
		logic [CFG_DATA_W-1:0] low;
		logic [CFG_DATA_W-1:0] high;
		for (int k = 0; k < 8; k++) begin
			low[8*k +: 8] = draw_pattern_char();
			high[8*k +: 8] = draw_pattern_char();
		end
		write_settings(low, high, draw_length());
	endtask

	// One occurrence of the pattern, with blanks now and then between its
	// characters and now and then a wrong character that breaks it.
	task automatic push_occurrence();
		for (int k = 0; k < used_length(); k++) begin
			if (k > 0 && $urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 2)) push_random(draw_blank());
			end
			if ($urandom_range(0, 11) == 0) begin
				push_random(CHAR_W'($urandom_range(0, 255)));
			end else begin
				push_random(pattern_char(k));
			end
		end
	endtask

	task automatic push_noise();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: push_random(pattern_char($urandom_range(0, used_length() - 1)));
			5, 6: push_random(draw_blank());
			default: push_random(CHAR_W'($urandom_range(0, 255)));
		endcase
	endtask

	initial begin : stimulus
		int seg_end;
		chars_low = '0;
		chars_high = '0;
		length_reg = LEN_W'(1);
		clear_text();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rows.
		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (DIRECTED_PLAN[i].kind == PLAN_SETTINGS) begin
				settle();
				write_settings(DIRECTED_PLAN[i].low, DIRECTED_PLAN[i].high,
					DIRECTED_PLAN[i].len);
			end else begin
				push_text(DIRECTED_PLAN[i].text, DIRECTED_PLAN[i].eot,
					DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
			end
		end

		// Hundreds of spaces against a pattern that starts with a space: the
		// merged count of the single cell runs into its limit of 255.
		settle();
		write_settings(64'h7820, '0, LEN_W'(2));
		for (int i = 0; i < 300; i++) begin
			push_text((i % 10 == 9) ? draw_blank() : CHAR_SPACE, 1'b0);
		end
		push_text(8'h78, 1'b1);

		// Random part: segments under fresh settings, mostly occurrences of the
		// pattern with random blanks and breaks, the rest noise. Some segments
		// end the text, others carry it over into the next settings.
		while (random_sent < RANDOM_WORDS) begin
			settle();
			idling = ($urandom_range(0, 3) != 0);
			write_random_settings();
			seg_end = random_sent + $urandom_range(20, 80);
			while (random_sent < seg_end) begin
				if ($urandom_range(0, 9) < 7) begin
					push_occurrence();
				end else begin
					push_noise();
				end
			end
			if ($urandom_range(0, 1) == 1) begin
				push_text(CHAR_W'($urandom_range(0, 255)), 1'b1);
				random_sent++;
			end
		end

		settle();
		repeat (5) @(negedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// A run that hangs is stopped here and reported as a mismatch.
	initial begin
		#(5_000_000);
		$display("Mismatches found");
		$finish;
	end

endmodule
